// File: hdl/mswipe_pkg.sv
// Package for the swipe gesture detector: field codes, register indexes,
// reset values and the swipe direction type. No dependencies.
`default_nettype none

package mswipe_pkg;

   localparam int unsigned VALUE_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned REQ_USER_WIDTH = 5;
   localparam int unsigned RSP_DATA_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOLDOWN = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] THRESHOLD_RESET = 16'd100;
   localparam logic [CSR_DATA_WIDTH-1:0] COOLDOWN_RESET = 16'd400;

   localparam logic ACT_MOTION = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   typedef struct packed {
      logic [1:0]             axis;
      logic                   is_relative;
      logic                   layer_active;
      logic                   action;
      logic [VALUE_WIDTH-1:0] motion_value;
      logic                   sync_flag;
   } item_type;

endpackage

`default_nettype wire

// File: hdl/motion_swipe_gesture_detector.sv
// Swipe gesture detector top level: input register, motion accumulators,
// cooldown counter and result register. Depends on mswipe_pkg.
//
// Use: items arrive on the req_ stream. A millisecond tick (action = 1) only
// counts the cooldown down. A motion item (action = 0) clears both sums while
// the layer is inactive, otherwise a relative X or Y delta is added to its
// saturating sum. When such a delta carries req_tlast (frame sync), once the
// cooldown has run out and either absolute sum reaches the threshold, one
// swipe direction is sent on the rsp_ stream, the sums clear and the cooldown
// restarts from cooldown_ms.
// Flow: an accepted item waits in the input register until it is processed,
// and its result, if any, is registered in the result register behind rsp_tvalid.
// Throughput: one item per cycle while the result stream does not stall, as each
// item reads and writes the sum and cooldown registers in one update.
// When rsp_tready is low with a result pending, the item in the input register
// waits and req_tready stays high only while that register is empty.
// Reset clears both sums, loads threshold 100, cooldown_ms 400 and a running
// cooldown of 400, and empties both registers. The csr_ port is always ready
// and should be written only while no item is in flight.
`default_nettype none

module motion_swipe_gesture_detector
   import mswipe_pkg::*;
#(
   parameter int unsigned SUM_WIDTH = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // motion_value [15:0]
   input  wire logic [VALUE_WIDTH-1:0]     req_tdata,
   // action [0], layer_active [1], is_relative [2], axis [4:3]
   input  wire logic [REQ_USER_WIDTH-1:0]  req_tuser,
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // direction [1:0], zero above
   output logic [RSP_DATA_WIDTH-1:0]       rsp_tdata,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int unsigned EXT_WIDTH = SUM_WIDTH + 1;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   logic                      s1_valid_ff, s1_valid_in;
   item_type                  s1_item_ff, s1_item_in;
   logic [SUM_WIDTH-1:0]      sum_x_ff, sum_x_in;
   logic [SUM_WIDTH-1:0]      sum_y_ff, sum_y_in;
   logic [CSR_DATA_WIDTH-1:0] cooldown_left_ff, cooldown_left_in;
   logic [CSR_DATA_WIDTH-1:0] threshold_ff, threshold_in;
   logic [CSR_DATA_WIDTH-1:0] cooldown_ms_ff, cooldown_ms_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   dir_type                   rsp_dir_ff, rsp_dir_in;

   logic                      proc;
   logic                      fire;
   logic                      add_x;
   logic                      add_y;
   logic [SUM_WIDTH-1:0]      acc;
   logic [EXT_WIDTH-1:0]      acc_ext;
   logic [SUM_WIDTH-1:0]      acc_sat;
   logic [SUM_WIDTH-1:0]      new_x;
   logic [SUM_WIDTH-1:0]      new_y;
   logic [SUM_WIDTH-1:0]      mag_x;
   logic [SUM_WIDTH-1:0]      mag_y;
   logic [SUM_WIDTH-1:0]      thr_ext;
   dir_type                   dir;

   assign proc = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || proc;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_WIDTH-2){1'b0}}, rsp_dir_ff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in = s1_item_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_item_in.action = req_tuser[0];
         s1_item_in.layer_active = req_tuser[1];
         s1_item_in.is_relative = req_tuser[2];
         s1_item_in.axis = req_tuser[4:3];
         s1_item_in.motion_value = req_tdata;
         s1_item_in.sync_flag = req_tlast;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
   end

   // One saturating adder serves whichever axis the item names.
   always_comb begin
      add_x = s1_item_ff.action == ACT_MOTION && s1_item_ff.layer_active
              && s1_item_ff.is_relative && s1_item_ff.axis == AXIS_X;
      add_y = s1_item_ff.action == ACT_MOTION && s1_item_ff.layer_active
              && s1_item_ff.is_relative && s1_item_ff.axis == AXIS_Y;
      acc = add_y ? sum_y_ff : sum_x_ff;
      acc_ext = {acc[SUM_WIDTH-1], acc}
                + {{(EXT_WIDTH-VALUE_WIDTH){s1_item_ff.motion_value[VALUE_WIDTH-1]}},
                   s1_item_ff.motion_value};
      if (acc_ext[EXT_WIDTH-1] != acc_ext[EXT_WIDTH-2]) begin
         acc_sat = acc_ext[EXT_WIDTH-1] ? SUM_MIN : SUM_MAX;
      end else begin
         acc_sat = acc_ext[SUM_WIDTH-1:0];
      end
      new_x = add_x ? acc_sat : sum_x_ff;
      new_y = add_y ? acc_sat : sum_y_ff;
      mag_x = new_x[SUM_WIDTH-1] ? (~new_x + 1'b1) : new_x;
      mag_y = new_y[SUM_WIDTH-1] ? (~new_y + 1'b1) : new_y;
      thr_ext = {{(SUM_WIDTH-CSR_DATA_WIDTH){1'b0}}, threshold_ff};
      fire = (add_x || add_y) && s1_item_ff.sync_flag && cooldown_left_ff == '0
             && (mag_x >= thr_ext || mag_y >= thr_ext);
      if (mag_x >= mag_y) begin
         dir = (!new_x[SUM_WIDTH-1] && new_x != '0) ? DIR_RIGHT : DIR_LEFT;
      end else begin
         dir = new_y[SUM_WIDTH-1] ? DIR_UP : DIR_DOWN;
      end
   end

   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      cooldown_left_in = cooldown_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dir_in = rsp_dir_ff;
      if (proc) begin
         if (s1_item_ff.action == ACT_TICK) begin
            if (cooldown_left_ff != '0) begin
               cooldown_left_in = cooldown_left_ff - 1'b1;
            end
         end else if (!s1_item_ff.layer_active || fire) begin
            sum_x_in = '0;
            sum_y_in = '0;
         end else begin
            sum_x_in = new_x;
            sum_y_in = new_y;
         end
         if (fire) begin
            cooldown_left_in = cooldown_ms_ff;
            rsp_valid_in = 1'b1;
            rsp_dir_in = dir;
         end
      end
   end

   always_comb begin
      threshold_in = threshold_ff;
      cooldown_ms_in = cooldown_ms_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata;
            CSR_COOLDOWN: cooldown_ms_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cooldown_left_ff <= COOLDOWN_RESET;
         threshold_ff <= THRESHOLD_RESET;
         cooldown_ms_ff <= COOLDOWN_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         cooldown_left_ff <= cooldown_left_in;
         threshold_ff <= threshold_in;
         cooldown_ms_ff <= cooldown_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_dir_ff <= rsp_dir_in;
   end

   // A swipe restarts the cooldown from the programmed value.
   assert property (@(posedge clock) disable iff (reset)
      proc && fire |=> cooldown_left_ff == $past(cooldown_ms_ff))
      else $error("cooldown not reloaded after a swipe");

   // A swipe leaves both sums cleared.
   assert property (@(posedge clock) disable iff (reset)
      proc && fire |=> sum_x_ff == '0 && sum_y_ff == '0)
      else $error("sums not cleared after a swipe");

   // Nothing fires while the cooldown is still running.
   assert property (@(posedge clock) disable iff (reset)
      cooldown_left_ff != '0 |-> !fire)
      else $error("swipe fired during cooldown");

   // A waiting item in the input register is neither lost nor overwritten.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !proc |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("pending item dropped or overwritten");

   // A new result is only loaded when the previous one has left.
   assert property (@(posedge clock) disable iff (reset)
      proc && fire |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overrun");

endmodule

`default_nettype wire

// File: tb/motion_swipe_gesture_detector_tb.sv
// Self-checking testbench for motion_swipe_gesture_detector: directed and random item
// streams, a swipe predictor kept in step with the csr writes, and randomized back-pressure.
// Depends on mswipe_pkg and the detector RTL.
`timescale 1ns / 1ps

module motion_swipe_gesture_detector_tb;
   import mswipe_pkg::*;

   localparam int SUM_W = 24;
   localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam logic [1:0] AXIS_OTHER = 2'd2;
   localparam logic [1:0] AXIS_SPARE = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_B = 2'd3;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata = '0;
   logic [REQ_USER_WIDTH-1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   motion_swipe_gesture_detector #(
      .SUM_WIDTH(SUM_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   item_type pending[$];
   item_type cur_item;
   dir_type swipe_due[$];
   int items_queued = 0;
   int items_taken = 0;
   int fails = 0;
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   int stall_req = 0;
   int stall_seen = 0;
   int hold_left = 0;

   logic signed [SUM_W-1:0] acc_x = '0;
   logic signed [SUM_W-1:0] acc_y = '0;
   logic [15:0] cool_left = COOLDOWN_RESET;
   logic [15:0] thr_reg = THRESHOLD_RESET;
   logic [15:0] cool_reg = COOLDOWN_RESET;

   task automatic predict_swipe(input item_type it);
      longint sum;
      longint mag_x;
      longint mag_y;
      if (it.action == ACT_TICK) begin
         if (cool_left != 0) cool_left = cool_left - 16'd1;
      end else if (!it.layer_active) begin
         acc_x = '0;
         acc_y = '0;
      end else if (it.is_relative && (it.axis == AXIS_X || it.axis == AXIS_Y)) begin
         sum = (it.axis == AXIS_X ? longint'(acc_x) : longint'(acc_y))
               + longint'($signed(it.motion_value));
         if (sum > SUM_HI) sum = SUM_HI;
         if (sum < SUM_LO) sum = SUM_LO;
         if (it.axis == AXIS_X) acc_x = sum[SUM_W-1:0];
         else acc_y = sum[SUM_W-1:0];
         if (it.sync_flag && cool_left == 0) begin
            mag_x = acc_x < 0 ? -longint'(acc_x) : longint'(acc_x);
            mag_y = acc_y < 0 ? -longint'(acc_y) : longint'(acc_y);
            if (mag_x >= longint'(thr_reg) || mag_y >= longint'(thr_reg)) begin
               if (mag_x >= mag_y) swipe_due.push_back(acc_x > 0 ? DIR_RIGHT : DIR_LEFT);
               else swipe_due.push_back(acc_y < 0 ? DIR_UP : DIR_DOWN);
               acc_x = '0;
               acc_y = '0;
               cool_left = cool_reg;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_swipe(cur_item);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
               cur_item = pending.pop_front();
               req_tdata <= cur_item.motion_value;
               req_tuser <= {cur_item.axis, cur_item.is_relative, cur_item.layer_active,
                             cur_item.action};
               req_tlast <= cur_item.sync_flag;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      dir_type exp_dir;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (swipe_due.size() == 0) begin
               $error("direction: expected no item, actual %0d", rsp_tdata);
               fails++;
            end else begin
               exp_dir = swipe_due.pop_front();
               if (rsp_tdata !== RSP_DATA_WIDTH'(exp_dir)) begin
                  $error("direction: expected %0d, actual %0d", exp_dir, rsp_tdata);
                  fails++;
               end
            end
         end
         if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   function automatic item_type mk(input logic act, input logic layer, input logic rel,
                                   input logic [1:0] ax, input logic [15:0] val,
                                   input logic sync);
      item_type it;
      it.action = act;
      it.layer_active = layer;
      it.is_relative = rel;
      it.axis = ax;
      it.motion_value = val;
      it.sync_flag = sync;
      return it;
   endfunction

   function automatic logic [15:0] rand_delta(input int vmax);
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'($urandom);
      if (r < 13) return 16'h8000;
      if (r < 16) return 16'h7fff;
      return 16'(int'($urandom_range(0, 2 * vmax)) - vmax);
   endfunction

   task automatic add_item(input item_type it);
      pending.push_back(it);
      items_queued++;
   endtask

   task automatic add_move(input logic [1:0] ax, input logic [15:0] val, input logic sync);
      add_item(mk(ACT_MOTION, 1'b1, 1'b1, ax, val, sync));
   endtask

   task automatic add_ticks(input int n);
      for (int i = 0; i < n; i++)
         add_item(mk(ACT_TICK, 1'($urandom), 1'($urandom), 2'($urandom), 16'($urandom),
                     1'($urandom)));
   endtask

   task automatic add_random(input int count, input int vmax);
      int made;
      int moves;
      int kind;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            moves = $urandom_range(1, 4);
            for (int m = 0; m < moves; m++)
               add_move($urandom_range(1) ? AXIS_Y : AXIS_X, rand_delta(vmax),
                        (m == moves - 1) || ($urandom_range(9) == 0));
            made += moves;
         end else if (kind < 85) begin
            moves = $urandom_range(1, 12);
            add_ticks(moves);
            made += moves;
         end else if (kind < 92) begin
            add_item(mk(ACT_MOTION, 1'b0, 1'($urandom), 2'($urandom), 16'($urandom),
                        1'($urandom)));
            made++;
         end else if (kind < 96) begin
            add_item(mk(ACT_MOTION, 1'b1, 1'b0, 2'($urandom), 16'($urandom), 1'($urandom)));
            made++;
         end else begin
            add_item(mk(ACT_MOTION, 1'b1, 1'b1, $urandom_range(1) ? AXIS_OTHER : AXIS_SPARE,
                        16'($urandom), 1'($urandom)));
            made++;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_THRESHOLD: thr_reg = val;
         CSR_COOLDOWN: cool_reg = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (items_taken != items_queued || swipe_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic start_phase(input logic [15:0] thr, input logic [15:0] cool,
                              input int unsigned s_idle, input int unsigned r_idle);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_COOLDOWN, cool);
      send_idle <= s_idle;
      recv_idle <= r_idle;
      add_ticks(30);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The cooldown of 400 from reset keeps running after cooldown_ms is rewritten.
      write_csr(CSR_THRESHOLD, 16'd100);
      write_csr(CSR_COOLDOWN, 16'd0);
      send_idle <= 17;
      recv_idle <= 71;
      add_ticks(399);
      add_move(AXIS_X, 16'd200, 1'b1);
      add_ticks(1);
      add_move(AXIS_Y, -16'sd1, 1'b1);
      add_move(AXIS_X, -16'sd150, 1'b0);
      add_move(AXIS_Y, 16'd150, 1'b1);
      add_move(AXIS_Y, -16'sd300, 1'b1);
      add_move(AXIS_Y, 16'd120, 1'b1);
      add_move(AXIS_X, 16'd99, 1'b1);
      add_item(mk(ACT_MOTION, 1'b0, 1'b1, AXIS_X, 16'd50, 1'b1));
      add_move(AXIS_X, 16'd1, 1'b1);
      add_item(mk(ACT_MOTION, 1'b1, 1'b0, AXIS_X, 16'h7fff, 1'b1));
      add_item(mk(ACT_MOTION, 1'b1, 1'b1, AXIS_OTHER, 16'd500, 1'b1));
      add_item(mk(ACT_MOTION, 1'b1, 1'b1, AXIS_SPARE, 16'd500, 1'b1));
      add_move(AXIS_X, 16'd99, 1'b1);
      add_move(AXIS_X, 16'h8000, 1'b1);
      add_move(AXIS_Y, 16'h7fff, 1'b1);
      add_item(mk(ACT_TICK, 1'b0, 1'b0, AXIS_SPARE, 16'hffff, 1'b1));
      add_move(AXIS_Y, 16'd0, 1'b1);
      wait_drained();

      // Zero threshold, and writes to unused register indexes that must change nothing.
      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_UNUSED_A, 16'hffff);
      write_csr(CSR_UNUSED_B, 16'h0001);
      add_move(AXIS_X, 16'd0, 1'b1);
      add_move(AXIS_Y, 16'd0, 1'b1);
      add_move(AXIS_Y, -16'sd5, 1'b1);
      wait_drained();

      start_phase(16'd1, 16'd0, 17, 71);
      add_random(80, 20);
      wait_drained();
      start_phase(16'd100, 16'd5, 71, 17);
      add_random(80, 80);
      wait_drained();
      start_phase(16'd500, 16'd20, 71, 17);
      add_random(80, 400);
      wait_drained();
      start_phase(16'd65535, 16'd0, 71, 17);
      add_random(80, 32767);
      wait_drained();
      start_phase(16'd0, 16'd3, 71, 17);
      add_random(60, 10);
      wait_drained();

      // Saturation of both sums at the top and bottom of their range. Without it the
      // larger X sum would win; saturated, the Y sum is one larger and wins.
      start_phase(16'd65535, 16'd0, 0, 0);
      repeat (270) add_move(AXIS_X, 16'h7fff, 1'b0);
      repeat (259) add_move(AXIS_Y, 16'h8000, 1'b0);
      add_move(AXIS_Y, 16'h8000, 1'b1);
      add_random(30, 32767);
      wait_drained();

      // Long receiver hold-off while every item fires, then a full drain.
      start_phase(16'd1, 16'd0, 0, 0);
      stall_req <= stall_req + 1;
      for (int i = 0; i < 60; i++)
         add_move(i % 2 ? AXIS_Y : AXIS_X,
                  $urandom_range(1) ? 16'($urandom_range(1, 1000))
                                    : -16'($urandom_range(1, 1000)), 1'b1);
      wait_drained();
      add_random(50, 50);
      wait_drained();

      start_phase(16'd2000, 16'd10, 0, 0);
      add_random(60, 1500);
      wait_drained();
      start_phase(16'd200, 16'd65535, 0, 0);
      add_random(50, 150);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fails == 0 && swipe_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/mswipe_pkg.sv
hdl/motion_swipe_gesture_detector.sv
tb/motion_swipe_gesture_detector_tb.sv
